@@ rtl/core/kfe_pkg.sv @@
// ----------------------------------------------------------------------------
// kfe_pkg
// Shared types, constants and helpers of the keyword field extractor.
// ----------------------------------------------------------------------------
package kfe_pkg;

   localparam int KFE_KEYWORD_MAX_BYTES = 8;
   localparam int KFE_LEN_W             = 4;
   localparam int KFE_CSR_IDX_W         = 8;

   localparam logic [KFE_CSR_IDX_W-1:0] CSR_KEYWORD_BYTES   = 8'd0;
   localparam logic [KFE_CSR_IDX_W-1:0] CSR_KEYWORD_LENGTH  = 8'd1;
   localparam logic [KFE_CSR_IDX_W-1:0] CSR_FIELD_NUMBER    = 8'd2;
   localparam logic [KFE_CSR_IDX_W-1:0] CSR_MAX_FIELD_CHARS = 8'd3;

   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;

   typedef enum logic [2:0] {
      PH_SEARCH = 3'd0,
      PH_BLANK  = 3'd1,
      PH_SKIP   = 3'd2,
      PH_EMIT   = 3'd3,
      PH_DONE   = 3'd4
   } kfe_phase_type;

   typedef enum logic [1:0] {
      KIND_CHAR    = 2'd0,
      KIND_FOUND   = 2'd1,
      KIND_MISSING = 2'd2
   } kfe_kind_type;

   typedef struct packed {
      logic [63:0]          keyword_bytes;
      logic [KFE_LEN_W-1:0] keyword_length;
      logic [7:0]           field_number;
      logic [7:0]           max_field_chars;
   } kfe_cfg_type;

   typedef struct packed {
      kfe_kind_type item_kind;
      logic [7:0]   field_char;
      logic         run_last;
   } kfe_result_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } kfe_win_ctl_type;

   function automatic logic is_blank(input logic [7:0] b);
      return (b == CHAR_SPACE) || (b == CHAR_TAB);
   endfunction

   function automatic logic is_delim(input logic [7:0] b);
      return (b == CHAR_COMMA) || (b == CHAR_CR) || (b == CHAR_LF);
   endfunction

   function automatic kfe_result_type make_result(input kfe_kind_type kind,
                                                  input logic [7:0]   ch);
      kfe_result_type r;
      r.item_kind  = kind;
      r.field_char = ch;
      r.run_last   = (kind != KIND_CHAR);
      return r;
   endfunction

endpackage

@@ rtl/core/kfe_window.sv @@
// ----------------------------------------------------------------------------
// kfe_window
// Sliding byte window and keyword compare against the incoming byte.
// ----------------------------------------------------------------------------
module kfe_window
   import kfe_pkg::*;
#(
   parameter int KEYWORD_MAX_BYTES = KFE_KEYWORD_MAX_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           text_byte,
   input  logic [63:0]          keyword_bytes,
   input  logic [KFE_LEN_W-1:0] keyword_length,
   input  kfe_win_ctl_type      ctl,
   output logic                 hit
);

   localparam int WW = 8 * KEYWORD_MAX_BYTES;

   logic [WW-1:0]          window_ff, window_in;
   logic [KFE_LEN_W-1:0]   seen_ff, seen_in;
   logic [WW-1:0]          window_next;
   logic [KFE_LEN_W-1:0]   seen_next;
   logic [KFE_LEN_W-1:0]   len;
   logic [KEYWORD_MAX_BYTES:1] hit_len;

   assign window_next = WW'({window_ff, text_byte});
   assign seen_next   = (seen_ff < KFE_LEN_W'(KEYWORD_MAX_BYTES)) ?
                        seen_ff + KFE_LEN_W'(1) : seen_ff;
   assign len         = (keyword_length > KFE_LEN_W'(KEYWORD_MAX_BYTES)) ?
                        KFE_LEN_W'(KEYWORD_MAX_BYTES) : keyword_length;

   // one compare set per candidate keyword length
   for (genvar l = 1; l <= KEYWORD_MAX_BYTES; l++) begin : g_len
      logic [l-1:0] eq;
      for (genvar k = 0; k < l; k++) begin : g_byte
         assign eq[k] = keyword_bytes[8*k +: 8] == window_next[8*(l-1-k) +: 8];
      end
      assign hit_len[l] = &eq;
   end

   always_comb begin
      hit = 1'b0;
      for (int l = 1; l <= KEYWORD_MAX_BYTES; l++) begin
         if (len == KFE_LEN_W'(l) && hit_len[l]) begin
            hit = 1'b1;
         end
      end
      hit = hit && (seen_next >= len);
   end

   always_comb begin
      window_in = window_ff;
      seen_in   = seen_ff;
      if (ctl.clear) begin
         window_in = '0;
         seen_in   = '0;
      end else if (ctl.shift) begin
         window_in = window_next;
         seen_in   = seen_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         seen_ff   <= '0;
      end else begin
         window_ff <= window_in;
         seen_ff   <= seen_in;
      end
   end

endmodule

@@ rtl/core/kfe_parser.sv @@
// ----------------------------------------------------------------------------
// kfe_parser
// Parse phase sequencer: blank skip, field counting, field emit and report.
// ----------------------------------------------------------------------------
module kfe_parser
   import kfe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [7:0]      text_byte,
   input  logic            end_of_text,
   input  kfe_cfg_type     cfg,
   input  logic            win_hit,
   output kfe_win_ctl_type win_ctl,
   output logic [1:0]      res_count,
   output kfe_result_type  res_slot [2]
);

   kfe_phase_type phase_ff, phase_in;
   logic [7:0]    counter_ff, counter_in;
   logic [7:0]    emitted_ff, emitted_in;
   logic          consumed;
   logic          do_emit;

   always_comb begin
      phase_in    = phase_ff;
      counter_in  = counter_ff;
      emitted_in  = emitted_ff;
      win_ctl     = '0;
      res_slot[0] = '0;
      res_slot[1] = '0;
      res_count   = '0;
      consumed    = 1'b0;
      do_emit     = 1'b0;
      if (in_valid) begin
         if (phase_ff == PH_SEARCH) begin
            if (cfg.keyword_length == '0) begin
               phase_in = PH_BLANK;
            end else begin
               consumed      = 1'b1;
               win_ctl.shift = 1'b1;
               if (win_hit) begin
                  phase_in = PH_BLANK;
               end
            end
         end
         if (!consumed) begin
            unique case (phase_in)
               PH_BLANK: begin
                  if (!is_blank(text_byte)) begin
                     if (counter_in == cfg.field_number) begin
                        phase_in   = PH_EMIT;
                        emitted_in = '0;
                        do_emit    = 1'b1;
                     end else if (text_byte == CHAR_COMMA) begin
                        counter_in = counter_in + 8'd1;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end
               end
               PH_SKIP: begin
                  if (text_byte == CHAR_COMMA) begin
                     counter_in = counter_in + 8'd1;
                     phase_in   = PH_BLANK;
                  end
               end
               PH_EMIT: begin
                  do_emit = 1'b1;
               end
               default: begin
               end
            endcase
         end
         if (do_emit) begin
            if (is_delim(text_byte) || emitted_in >= cfg.max_field_chars) begin
               res_slot[res_count[0]] = make_result(KIND_FOUND, 8'd0);
               res_count              = res_count + 2'd1;
               phase_in               = PH_DONE;
            end else begin
               res_slot[res_count[0]] = make_result(KIND_CHAR, text_byte);
               res_count              = res_count + 2'd1;
               emitted_in             = emitted_in + 8'd1;
               if (emitted_in >= cfg.max_field_chars) begin
                  res_slot[res_count[0]] = make_result(KIND_FOUND, 8'd0);
                  res_count              = res_count + 2'd1;
                  phase_in               = PH_DONE;
               end
            end
         end
         if (end_of_text) begin
            if (phase_in == PH_EMIT) begin
               res_slot[res_count[0]] = make_result(KIND_FOUND, 8'd0);
               res_count              = res_count + 2'd1;
            end else if (phase_in != PH_DONE) begin
               res_slot[res_count[0]] = make_result(KIND_MISSING, 8'd0);
               res_count              = res_count + 2'd1;
            end
            phase_in      = PH_SEARCH;
            counter_in    = '0;
            emitted_in    = '0;
            win_ctl.clear = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SEARCH;
         counter_ff <= '0;
         emitted_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         counter_ff <= counter_in;
         emitted_ff <= emitted_in;
      end
   end

endmodule

@@ rtl/core/kfe_rsp_queue.sv @@
// ----------------------------------------------------------------------------
// kfe_rsp_queue
// Small result queue, up to two items in per cycle, one out per ready cycle.
// ----------------------------------------------------------------------------
module kfe_rsp_queue
   import kfe_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic [1:0]     push_count,
   input  kfe_result_type push_slot [2],
   output logic           space_ok,
   output logic           out_valid,
   input  logic           out_ready,
   output kfe_result_type out_item
);

   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   kfe_result_type mem_ff [DEPTH];
   logic [PW-1:0]  wr_ff, wr_in;
   logic [PW-1:0]  rd_ff, rd_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           pop;

   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   assign space_ok  = (count_ff <= CW'(DEPTH - 2));

   always_comb begin
      wr_in    = wr_ff + PW'(push_count);
      rd_in    = pop ? rd_ff + PW'(1) : rd_ff;
      count_in = count_ff + CW'(push_count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ff] <= push_slot[0];
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ff + PW'(1)] <= push_slot[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/core/keyword_field_extractor.sv @@
// ----------------------------------------------------------------------------
// keyword_field_extractor
// Finds a keyword in a byte stream and emits one comma-separated field after it.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_tvalid/req_tready | tdata text_byte, tlast end_of_text
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata field_char, tuser item_kind,
//          |           |                       | tlast run_last
//  csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
//  one input item per ready cycle; each item is parsed in the cycle it is accepted
//  and its zero to two results land in a four-entry result queue
//  req_tready drops while the queue has fewer than two free entries
//  results are written into the result queue and reach rsp from there, behind any older results
//  reset clears parse state and queue and loads the register defaults
// ----------------------------------------------------------------------------
module keyword_field_extractor
   import kfe_pkg::*;
#(
   parameter int KEYWORD_MAX_BYTES = KFE_KEYWORD_MAX_BYTES
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // text_byte
   input  logic                     req_tlast,   // end_of_text
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,   // field_char
   output logic [1:0]               rsp_tuser,   // item_kind
   output logic                     rsp_tlast,   // run_last
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [KFE_CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]              csr_data
);

   kfe_cfg_type     cfg_ff, cfg_in;
   kfe_win_ctl_type win_ctl;
   kfe_result_type  res_slot [2];
   kfe_result_type  out_item;
   logic [1:0]      res_count;
   logic            win_hit;
   logic            space_ok;
   logic            in_accept;

   assign csr_ready  = 1'b1;
   assign req_tready = space_ok;
   assign in_accept  = req_tvalid && req_tready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_KEYWORD_BYTES:   cfg_in.keyword_bytes   = csr_data;
            CSR_KEYWORD_LENGTH:  cfg_in.keyword_length  = csr_data[KFE_LEN_W-1:0];
            CSR_FIELD_NUMBER:    cfg_in.field_number    = csr_data[7:0];
            CSR_MAX_FIELD_CHARS: cfg_in.max_field_chars = csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.keyword_bytes   <= '0;
         cfg_ff.keyword_length  <= KFE_LEN_W'(1);
         cfg_ff.field_number    <= '0;
         cfg_ff.max_field_chars <= 8'd31;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   kfe_window #(
      .KEYWORD_MAX_BYTES(KEYWORD_MAX_BYTES)
   ) u_window (
      .clock          (clock),
      .reset          (reset),
      .text_byte      (req_tdata),
      .keyword_bytes  (cfg_ff.keyword_bytes),
      .keyword_length (cfg_ff.keyword_length),
      .ctl            (win_ctl),
      .hit            (win_hit)
   );

   kfe_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (in_accept),
      .text_byte   (req_tdata),
      .end_of_text (req_tlast),
      .cfg         (cfg_ff),
      .win_hit     (win_hit),
      .win_ctl     (win_ctl),
      .res_count   (res_count),
      .res_slot    (res_slot)
   );

   kfe_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (res_count),
      .push_slot  (res_slot),
      .space_ok   (space_ok),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_item   (out_item)
   );

   assign rsp_tdata = out_item.field_char;
   assign rsp_tuser = out_item.item_kind;
   assign rsp_tlast = out_item.run_last;

endmodule

@@ sim/keyword_field_extractor_checker.sv @@
// ----------------------------------------------------------------------------
// keyword_field_extractor_checker
// Watches the text, result and register channels of the keyword field
// extractor. It keeps its own copy of the registers and the parse state,
// works out the field characters and the found/not-found item that each
// accepted text byte should cause, and compares every accepted result item
// field by field against the oldest outstanding one.
// ----------------------------------------------------------------------------
module keyword_field_extractor_checker
   import kfe_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [7:0]               req_tdata,   // text_byte
   input  logic                     req_tlast,   // end_of_text
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [7:0]               rsp_tdata,   // field_char
   input  logic [1:0]               rsp_tuser,   // item_kind
   input  logic                     rsp_tlast,   // run_last
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [KFE_CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]              csr_data,
   output int unsigned              fail_count,
   output int unsigned              items_outstanding
);

   kfe_cfg_type    cfg;
   logic [63:0]    recent_bytes;
   logic [3:0]     recent_count;
   kfe_phase_type  phase;
   logic [7:0]     fields_passed;
   logic [7:0]     field_chars;
   kfe_result_type expected_field_items[$];

   task automatic report_error(input string msg);
      $display("error at %0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic clear_parse();
      recent_bytes  = '0;
      recent_count  = '0;
      phase         = PH_SEARCH;
      fields_passed = '0;
      field_chars   = '0;
   endtask

   // a report item closes the field
   task automatic expect_item(input kfe_kind_type kind, input logic [7:0] ch);
      kfe_result_type r;
      r.item_kind  = kind;
      r.field_char = ch;
      r.run_last   = (kind != KIND_CHAR);
      expected_field_items.push_back(r);
      if (kind != KIND_CHAR) phase = PH_DONE;
   endtask

   task automatic emit_char(input logic [7:0] b);
      if (b == CHAR_COMMA || b == CHAR_CR || b == CHAR_LF || field_chars >= cfg.max_field_chars)
         expect_item(KIND_FOUND, 8'h00);
      else begin
         expect_item(KIND_CHAR, b);
         field_chars = field_chars + 8'd1;
         if (field_chars >= cfg.max_field_chars) expect_item(KIND_FOUND, 8'h00);
      end
   endtask

   task automatic open_field(input logic [7:0] b);
      if (fields_passed == cfg.field_number) begin
         phase       = PH_EMIT;
         field_chars = '0;
         emit_char(b);
      end else if (b == CHAR_COMMA) begin
         fields_passed = fields_passed + 8'd1;
         phase         = PH_BLANK;
      end else
         phase = PH_SKIP;
   endtask

   // oldest keyword byte sits highest in the window
   function automatic logic keyword_hit(input int unsigned len);
      int unsigned k;
      for (k = 0; k < len; k++)
         if (cfg.keyword_bytes[8*k +: 8] != recent_bytes[8*(len-1-k) +: 8]) return 1'b0;
      return 1'b1;
   endfunction

   task automatic extract_step(input logic [7:0] b, input logic eot);
      int unsigned len;
      logic        taken;
      len   = (cfg.keyword_length > KFE_KEYWORD_MAX_BYTES) ? KFE_KEYWORD_MAX_BYTES
                                                          : cfg.keyword_length;
      taken = 1'b0;
      if (phase == PH_SEARCH) begin
         if (len == 0)
            phase = PH_BLANK;
         else begin
            taken        = 1'b1;
            recent_bytes = {recent_bytes[55:0], b};
            if (recent_count < KFE_KEYWORD_MAX_BYTES) recent_count = recent_count + 4'd1;
            if (recent_count >= len && keyword_hit(len)) phase = PH_BLANK;
         end
      end
      if (!taken) begin
         case (phase)
            PH_BLANK: begin
               if (b != CHAR_SPACE && b != CHAR_TAB) open_field(b);
            end
            PH_SKIP: begin
               if (b == CHAR_COMMA) begin
                  fields_passed = fields_passed + 8'd1;
                  phase         = PH_BLANK;
               end
            end
            PH_EMIT: emit_char(b);
            default: ;
         endcase
      end
      if (eot) begin
         if (phase == PH_EMIT) expect_item(KIND_FOUND, 8'h00);
         else if (phase != PH_DONE) expect_item(KIND_MISSING, 8'h00);
         clear_parse();
      end
   endtask

   task automatic check_result();
      kfe_result_type want;
      if (expected_field_items.size() == 0)
         report_error($sformatf("unexpected result: kind %0d char %02h last %0b",
                                rsp_tuser, rsp_tdata, rsp_tlast));
      else begin
         want = expected_field_items.pop_front();
         if (rsp_tuser != want.item_kind)
            report_error($sformatf("item_kind got %0d want %0d", rsp_tuser, want.item_kind));
         if (rsp_tdata != want.field_char)
            report_error($sformatf("field_char got %02h want %02h", rsp_tdata, want.field_char));
         if (rsp_tlast != want.run_last)
            report_error($sformatf("run_last got %0b want %0b", rsp_tlast, want.run_last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg.keyword_bytes   = 64'h0;
         cfg.keyword_length  = 4'd1;
         cfg.field_number    = 8'd0;
         cfg.max_field_chars = 8'd31;
         clear_parse();
         expected_field_items.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KEYWORD_BYTES:   cfg.keyword_bytes   = csr_data;
               CSR_KEYWORD_LENGTH:  cfg.keyword_length  = csr_data[KFE_LEN_W-1:0];
               CSR_FIELD_NUMBER:    cfg.field_number    = csr_data[7:0];
               CSR_MAX_FIELD_CHARS: cfg.max_field_chars = csr_data[7:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) extract_step(req_tdata, req_tlast);
      end
      items_outstanding <= expected_field_items.size();
   end

endmodule

@@ sim/keyword_field_extractor_tb.sv @@
// ----------------------------------------------------------------------------
// keyword_field_extractor_tb
// Drives reply text into the keyword field extractor: a short directed run
// over blanks, skipped fields, the length limit, empty fields, zero bytes and
// end of text inside and before the field, then random replies built around
// the keyword under a series of register settings and idle patterns. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module keyword_field_extractor_tb;
   import kfe_pkg::*;

   localparam int unsigned ITEM_TARGET    = 1450;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam logic [KFE_CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 8'hFF;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [7:0]               req_tdata;   // text_byte
   logic                     req_tlast;   // end_of_text
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [7:0]               rsp_tdata;   // field_char
   logic [1:0]               rsp_tuser;   // item_kind
   logic                     rsp_tlast;   // run_last
   logic                     csr_valid;
   logic                     csr_ready;
   logic [KFE_CSR_IDX_W-1:0] csr_index;
   logic [63:0]              csr_data;

   int unsigned fail_count;
   int unsigned items_outstanding;
   logic        req_taken = 1'b0;
   logic        csr_taken = 1'b0;
   int unsigned quiet_cycles = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned items_sent = 0;
   int unsigned segment_count = 0;
   logic [63:0] kw_cur;
   int unsigned klen_cur;
   int unsigned fnum_cur;

   keyword_field_extractor uut (.*);

   keyword_field_extractor_checker checker_i (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready;
      csr_taken <= csr_valid && csr_ready;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   task automatic send_text_byte(input logic [7:0] b, input logic eot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eot;
      do @(negedge clock); while (!req_taken);
      items_sent++;
   endtask

   task automatic send_string(input string s, input logic eot_last);
      int unsigned i;
      for (i = 0; i < s.len(); i++) send_text_byte(s[i], eot_last && (i == s.len() - 1));
   endtask

   task automatic write_reg(input logic [KFE_CSR_IDX_W-1:0] idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(negedge clock); while (!csr_taken);
   endtask

   task automatic program_regs(input logic [63:0] kw, input int unsigned klen,
                               input int unsigned fnum, input int unsigned maxc);
      kw_cur   = kw;
      klen_cur = klen;
      fnum_cur = fnum;
      write_reg(CSR_KEYWORD_BYTES, kw);
      write_reg(CSR_KEYWORD_LENGTH, 64'(klen));
      write_reg(CSR_FIELD_NUMBER, 64'(fnum));
      write_reg(CSR_MAX_FIELD_CHARS, 64'(maxc));
      write_reg(CSR_UNUSED_INDEX, {$urandom, $urandom});
      csr_valid <= 1'b0;
   endtask

   // lets the block drain before registers change
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (items_outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [63:0] random_keyword();
      logic [63:0] kw;
      int unsigned k;
      for (k = 0; k < 8; k++) kw[8*k +: 8] = 8'($urandom_range(8'h41, 8'h5A));
      return kw;
   endfunction

   function automatic logic [7:0] pick_blank();
      return $urandom_range(1) ? CHAR_SPACE : CHAR_TAB;
   endfunction

   // partial keywords in the noise exercise the sliding window
   function automatic logic [7:0] pick_noise(input int unsigned len_eff);
      int unsigned idx;
      if (len_eff != 0 && $urandom_range(99) < 30) begin
         idx = $urandom_range(0, len_eff - 1);
         return kw_cur[8*idx +: 8];
      end
      return 8'($urandom_range(1, 255));
   endfunction

   task automatic send_reply();
      logic [7:0]  text[$];
      int unsigned len_eff, n_fields, flen_max, r, k, f, cut;
      len_eff = (klen_cur > KFE_KEYWORD_MAX_BYTES) ? KFE_KEYWORD_MAX_BYTES : klen_cur;
      repeat ($urandom_range(0, 5)) text.push_back(pick_noise(len_eff));
      if ($urandom_range(99) < 88) begin
         for (k = 0; k < len_eff; k++) text.push_back(kw_cur[8*k +: 8]);
         repeat ($urandom_range(0, 2)) text.push_back(pick_blank());
         n_fields = ($urandom_range(99) < 12) ? fnum_cur : fnum_cur + 1 + $urandom_range(0, 1);
         flen_max = (fnum_cur > 8) ? 1 : 7;
         for (f = 0; f < n_fields; f++) begin
            if (f != 0) begin
               text.push_back(CHAR_COMMA);
               repeat ($urandom_range(0, 1)) text.push_back(pick_blank());
            end
            repeat ($urandom_range(0, flen_max)) begin
               r = $urandom_range(99);
               if (r < 5) text.push_back(pick_blank());
               else if (r < 8) text.push_back(CHAR_CR);
               else if (r < 11) text.push_back(CHAR_LF);
               else if (r < 14) text.push_back(CHAR_COMMA);
               else if (r < 24) text.push_back(8'($urandom_range(1, 255)));
               else text.push_back(8'($urandom_range(8'h30, 8'h7A)));
            end
         end
         if ($urandom_range(1) == 1) begin
            text.push_back(CHAR_CR);
            text.push_back(CHAR_LF);
         end
      end else
         repeat ($urandom_range(1, 12)) text.push_back(pick_noise(len_eff));
      // cut short now and then
      if (text.size() > 1 && $urandom_range(99) < 10) begin
         cut = $urandom_range(1, text.size() - 1);
         while (text.size() > cut) text.delete(text.size() - 1);
      end
      if (text.size() == 0) text.push_back(8'h41);
      for (k = 0; k < text.size(); k++) send_text_byte(text[k], k == text.size() - 1);
   endtask

   task automatic run_segment(input logic [63:0] kw, input int unsigned klen,
                              input int unsigned fnum, input int unsigned maxc,
                              input int unsigned quota);
      int unsigned start;
      wait_idle();
      case (segment_count % 4)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 84; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 84; end
         default: begin send_idle_pct = 14; rsp_stall_pct = 14; end
      endcase
      segment_count++;
      program_regs(kw, klen, fnum, maxc);
      start = items_sent;
      while (items_sent - start < quota) begin
         if ($urandom_range(99) < 3) wait_idle();
         send_reply();
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = CSR_KEYWORD_BYTES;
      csr_data   = 64'h0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // keyword "ID", second field, three characters at most
      program_regs(64'h4449, 2, 1, 3);
      send_string("ID \tx, bcde", 1'b1);
      send_string("ID,,", 1'b0);
      send_text_byte(8'hFF, 1'b1);
      send_text_byte("Q", 1'b0);
      send_text_byte(8'h00, 1'b0);
      send_string("IDa", 1'b1);
      send_string("IDq,r", 1'b1);

      run_segment(random_keyword(), 4, 1, 8, 120);
      run_segment(random_keyword(), 1, 0, 0, 120);
      run_segment(random_keyword(), 8, 2, 3, 120);
      run_segment(random_keyword(), 0, 1, 255, 120);
      run_segment(random_keyword(), 15, 3, 5, 120);
      run_segment(64'h0, 2, 255, 1, 1);
      run_segment({64{1'b1}}, 5, 0, 2, 120);
      while (items_sent < ITEM_TARGET)
         run_segment(random_keyword(), $urandom_range(1, 8), $urandom_range(0, 4),
                     $urandom_range(0, 12), 150);

      req_tvalid <= 1'b0;
      while (items_outstanding != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/kfe_pkg.sv
rtl/core/kfe_window.sv
rtl/core/kfe_parser.sv
rtl/core/kfe_rsp_queue.sv
rtl/core/keyword_field_extractor.sv
sim/keyword_field_extractor_checker.sv
sim/keyword_field_extractor_tb.sv
